// ----- rtl/hco_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hco_pkg
// shared widths, register indexes, pattern codes and types of the cursor overlay
// ----------------------------------------------------------------------------
package hco_pkg;

  localparam int CURSOR_SIZE_DEF = 64;

  localparam int PIX_X_W     = 11;
  localparam int PIX_Y_W     = 12;
  localparam int OFS_W       = 8;
  localparam int RGB_W       = 24;
  localparam int INDEX_W     = 9;
  localparam int WORD_W      = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_POS_X   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_POS_Y   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_H_OFS   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_V_OFS   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLOUR0 = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLOUR1 = 3'd6;

  // item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  // two-bit pattern codes
  localparam logic [1:0] CODE_COLOUR0    = 2'd0;
  localparam logic [1:0] CODE_COLOUR1    = 2'd1;
  localparam logic [1:0] CODE_TRANSPARENT = 2'd2;
  localparam logic [1:0] CODE_INVERT     = 2'd3;

  typedef struct packed {
    logic               enable;
    logic [PIX_X_W-1:0] pos_x;
    logic [PIX_Y_W-1:0] pos_y;
    logic [OFS_W-1:0]   h_offset;
    logic [OFS_W-1:0]   v_offset;
    logic [RGB_W-1:0]   colour_zero;
    logic [RGB_W-1:0]   colour_one;
  } cfg_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] pix_sel;
  } hit_info_t;

endpackage

// ----- rtl/hco_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hco_in_if
// input channel: pattern loads and screen pixels
// ----------------------------------------------------------------------------
interface hco_in_if
  import hco_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [INDEX_W-1:0] pattern_index;
  logic [WORD_W-1:0]  pattern_word;
  logic [PIX_X_W-1:0] pixel_x;
  logic [PIX_Y_W-1:0] pixel_y;
  logic [RGB_W-1:0]   background;

  modport source (output valid, mode, pattern_index, pattern_word, pixel_x, pixel_y,
                  background, input ready);
  modport sink (input valid, mode, pattern_index, pattern_word, pixel_x, pixel_y,
                background, output ready);
endinterface

// ----- rtl/hco_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hco_out_if
// output channel: composed pixels
// ----------------------------------------------------------------------------
interface hco_out_if
  import hco_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [RGB_W-1:0] pixel_out;
  logic             cursor_hit;

  modport source (output valid, pixel_out, cursor_hit, input ready);
  modport sink (input valid, pixel_out, cursor_hit, output ready);
endinterface

// ----- rtl/hco_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hco_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module hco_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/hco_hit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hco_hit
// cursor window test and pattern word address for one screen pixel
// ----------------------------------------------------------------------------
module hco_hit
  import hco_pkg::*;
#(
  parameter int CURSOR_SIZE = CURSOR_SIZE_DEF
) (
  input  cfg_t                                           cfg,
  input  logic [PIX_X_W-1:0]                             pixel_x,
  input  logic [PIX_Y_W-1:0]                             pixel_y,
  output hit_info_t                                      info,
  output logic [$clog2(CURSOR_SIZE * (CURSOR_SIZE / 8))-1:0] addr
);

  localparam int WPR    = CURSOR_SIZE / 8;
  localparam int DEPTH  = CURSOR_SIZE * WPR;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = ADDR_W + 1;
  localparam int POS_W  = $clog2(CURSOR_SIZE);

  logic [PIX_X_W-1:0] dx;
  logic [PIX_Y_W-1:0] dy;
  logic [PIX_Y_W-1:0] col;
  logic               dx_ok;
  logic               dy_ok;
  logic               col_ok;
  logic               row_ok;
  logic [IDX_W-1:0]   idx;
  logic               idx_ok;

  always_comb begin
    dx_ok  = pixel_x >= cfg.pos_x;
    dy_ok  = pixel_y >= cfg.pos_y;
    dx     = pixel_x - cfg.pos_x;
    dy     = pixel_y - cfg.pos_y;
    col    = PIX_Y_W'(dx) + PIX_Y_W'(cfg.h_offset);
    col_ok = col <= PIX_Y_W'(CURSOR_SIZE - 1);
    // drawn rows end short of the last one, and earlier still with v_offset
    row_ok = ({1'b0, dy} + (PIX_Y_W + 1)'(cfg.v_offset)) < (PIX_Y_W + 1)'(CURSOR_SIZE - 1);
    idx    = IDX_W'(dy[POS_W-1:0]) * IDX_W'(WPR) + IDX_W'(col[POS_W-1:0] >> 3);
    idx_ok = idx < IDX_W'(DEPTH);
    info.hit     = cfg.enable & dx_ok & dy_ok & col_ok & row_ok & idx_ok;
    info.pix_sel = col[2:0];
    addr         = idx[ADDR_W-1:0];
  end

endmodule

// ----- rtl/hardware_cursor_overlay.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hardware_cursor_overlay
// two-bit hardware pointer laid over an rgb888 pixel stream
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake     payload
//  in_word   in   valid/ready   mode, pattern_index, pattern_word, pixel_x,
//                               pixel_y, background
//  out_word  out  valid/ready   pixel_out, cursor_hit
//  cfg       in   cfg_write     cfg_index, cfg_data (write only)
//
//  one word in and one word out per clock when the sink keeps ready high;
//  each word passes the registered read of the pattern ram
//  and the output register behind the compose logic
//  rst is synchronous and clears valid flags and config, never the ram
//  a stalled output holds its word, the middle stage still takes one more
//  input word, then in_word.ready drops until the output moves
//
module hardware_cursor_overlay
  import hco_pkg::*;
#(
  parameter int CURSOR_SIZE = CURSOR_SIZE_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  hco_in_if.sink                 in_word,
  hco_out_if.source              out_word
);

  localparam int WPR    = CURSOR_SIZE / 8;
  localparam int DEPTH  = CURSOR_SIZE * WPR;
  localparam int ADDR_W = $clog2(DEPTH);

  // configuration registers
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ENABLE:  cfg.enable      <= cfg_data[0];
        CFG_POS_X:   cfg.pos_x       <= cfg_data[PIX_X_W-1:0];
        CFG_POS_Y:   cfg.pos_y       <= cfg_data[PIX_Y_W-1:0];
        CFG_H_OFS:   cfg.h_offset    <= cfg_data[OFS_W-1:0];
        CFG_V_OFS:   cfg.v_offset    <= cfg_data[OFS_W-1:0];
        CFG_COLOUR0: cfg.colour_zero <= cfg_data[RGB_W-1:0];
        CFG_COLOUR1: cfg.colour_one  <= cfg_data[RGB_W-1:0];
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

  // pipeline enables: each stage moves when its successor has room
  logic out_valid;
  logic s1_valid;
  logic out_en;
  logic s1_en;
  logic in_take;

  assign out_en        = !out_valid || out_word.ready;
  assign s1_en         = !s1_valid || out_en;
  assign in_word.ready = s1_en;
  assign in_take       = in_word.valid && s1_en;

  // stage 0: window test and ram address straight off the input word
  hit_info_t           hit0;
  logic [ADDR_W-1:0]   rd_addr;
  logic                load_ok;

  hco_hit #(
    .CURSOR_SIZE(CURSOR_SIZE)
  ) u_hit (
    .cfg     (cfg),
    .pixel_x (in_word.pixel_x),
    .pixel_y (in_word.pixel_y),
    .info    (hit0),
    .addr    (rd_addr)
  );

  // loads beyond the store depth are dropped
  assign load_ok = 32'(in_word.pattern_index) < 32'(DEPTH);

  logic [WORD_W-1:0] ram_q;

  hco_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (in_take && (in_word.mode == MODE_LOAD) && load_ok),
    .waddr (ADDR_W'(in_word.pattern_index)),
    .wdata (in_word.pattern_word),
    .re    (s1_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // stage 1: ram word arrives, side info waits next to it
  logic             s1_mode;
  hit_info_t        s1_info;
  logic [RGB_W-1:0] s1_bg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_mode <= in_word.mode;
      s1_info <= (in_word.mode == MODE_PIXEL) ? hit0 : '0;
      s1_bg   <= in_word.background;
    end
  end

  // pick the two-bit code for this pixel and compose
  logic [1:0]       code;
  logic [RGB_W-1:0] pixel_next;
  logic             hit_next;

  always_comb begin
    code = ram_q[2 * s1_info.pix_sel +: 2];
    hit_next = 1'b0;
    if (s1_mode == MODE_LOAD) begin
      pixel_next = '0;
    end else if (!s1_info.hit) begin
      pixel_next = s1_bg;
    end else begin
      hit_next = 1'b1;
      unique case (code)
        CODE_COLOUR0:     pixel_next = cfg.colour_zero;
        CODE_COLOUR1:     pixel_next = cfg.colour_one;
        CODE_TRANSPARENT: pixel_next = s1_bg;
        CODE_INVERT:      pixel_next = ~s1_bg;
        default:          pixel_next = s1_bg;
      endcase
    end
  end

  // stage 2: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_word.pixel_out  <= pixel_next;
      out_word.cursor_hit <= hit_next;
    end
  end

  assign out_word.valid = out_valid;

  // checks
  a_hit_needs_enable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.cursor_hit |-> cfg.enable)
    else $error("cursor hit reported while cursor disabled");

  a_load_never_hits: assert property (@(posedge clk) disable iff (rst)
    s1_valid && (s1_mode == MODE_LOAD) |-> !s1_info.hit)
    else $error("load word carries a cursor hit");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_word.ready |-> s1_valid && out_valid && !out_word.ready)
    else $error("input stalled with room in the pipeline");

  a_output_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_word.ready |=> s1_valid && out_valid)
    else $error("pipeline word lost during output stall");

endmodule

// ----- tb/tb_hardware_cursor_overlay.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hardware_cursor_overlay
// self-checking bench for the cursor overlay: pattern loads and screen pixels
// go in through a queued driver with random gaps, composed pixels come back
// through a stalling sink, and a local model of the cursor rules checks every
// output word in order; register settings change between drained phases
// ----------------------------------------------------------------------------
module tb_hardware_cursor_overlay;
  import hco_pkg::*;

  localparam int CURSOR_SIZE     = CURSOR_SIZE_DEF;
  localparam int WORDS_PER_ROW   = CURSOR_SIZE / 8;
  localparam int STORE_DEPTH     = CURSOR_SIZE * WORDS_PER_ROW;
  localparam int RANDOM_PHASES   = 12;
  localparam int WORDS_PER_PHASE = 128;
  localparam int CYCLE_LIMIT     = 600000;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic [RGB_W-1:0]       RGB_WHITE  = 24'hFFFFFF;

  // one input word as it travels to the block
  typedef struct packed {
    logic               mode;
    logic [INDEX_W-1:0] pattern_index;
    logic [WORD_W-1:0]  pattern_word;
    logic [PIX_X_W-1:0] pixel_x;
    logic [PIX_Y_W-1:0] pixel_y;
    logic [RGB_W-1:0]   background;
  } pix_req_t;

  // one composed output word
  typedef struct packed {
    logic [RGB_W-1:0] pixel;
    logic             hit;
  } overlay_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  hco_in_if  pix_in ();
  hco_out_if pix_out ();

  hardware_cursor_overlay #(
    .CURSOR_SIZE(CURSOR_SIZE)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_word  (pix_in),
    .out_word (pix_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bench copy of the register file and of the pattern ram
  cfg_t              cursor_cfg;
  logic [WORD_W-1:0] pattern_mem [STORE_DEPTH];
  // which ram words the generator has already scheduled a load for
  bit                loaded_mem [STORE_DEPTH];

  pix_req_t pending_words [$];
  overlay_t expected_pixels [$];

  int       queued_count = 0;
  int       mismatches = 0;
  int       cycle_count = 0;
  int       gap_left = 0;
  int       stall_left = 0;
  bit       source_steady = 1'b0;
  bit       sink_steady = 1'b0;
  logic     in_fire = 1'b0;
  pix_req_t cur_req;
  pix_req_t seen_req;
  overlay_t got_px;
  overlay_t want_px;

  // mostly short gaps, now and then a long one; a steady side never idles
  function automatic int idle_len(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // cursor geometry: is (px, py) inside the drawn area, and which ram word
  // and pattern column it maps to
  function automatic bit cursor_hit_at(input logic [PIX_X_W-1:0] px,
                                       input logic [PIX_Y_W-1:0] py,
                                       output int word_idx, output int col);
    int dx;
    int dy;
    int rows;
    dx = int'(px) - int'(cursor_cfg.pos_x);
    dy = int'(py) - int'(cursor_cfg.pos_y);
    col = dx + int'(cursor_cfg.h_offset);
    // rows at or past (size - 1 - v_offset) are never drawn
    rows = CURSOR_SIZE - 1 - int'(cursor_cfg.v_offset);
    word_idx = dy * WORDS_PER_ROW + col / 8;
    return cursor_cfg.enable && dx >= 0 && col <= CURSOR_SIZE - 1 && dy >= 0 && dy < rows;
  endfunction

  // applies one accepted word to the ram copy and returns the composed pixel
  function automatic overlay_t compose_pixel(input pix_req_t req);
    overlay_t   res;
    int         idx;
    int         col;
    logic [1:0] code;
    res.pixel = '0;
    res.hit   = 1'b0;
    if (req.mode == MODE_LOAD) begin
      if (int'(req.pattern_index) < STORE_DEPTH) pattern_mem[req.pattern_index] = req.pattern_word;
    end else if (cursor_hit_at(req.pixel_x, req.pixel_y, idx, col)) begin
      res.hit = 1'b1;
      // leftmost pixel of a word sits in bits 1:0
      code = pattern_mem[idx][2 * (col % 8) +: 2];
      case (code)
        CODE_COLOUR0:     res.pixel = cursor_cfg.colour_zero;
        CODE_COLOUR1:     res.pixel = cursor_cfg.colour_one;
        CODE_TRANSPARENT: res.pixel = req.background;
        default:          res.pixel = ~req.background;
      endcase
    end else begin
      res.pixel = req.background;
    end
    return res;
  endfunction

  function automatic pix_req_t scrambled_req();
    pix_req_t req;
    req.mode          = $urandom_range(0, 1);
    req.pattern_index = $urandom_range(0, (1 << INDEX_W) - 1);
    req.pattern_word  = $urandom_range(0, (1 << WORD_W) - 1);
    req.pixel_x       = $urandom_range(0, (1 << PIX_X_W) - 1);
    req.pixel_y       = $urandom_range(0, (1 << PIX_Y_W) - 1);
    req.background    = $urandom_range(0, (1 << RGB_W) - 1);
    return req;
  endfunction

  function automatic logic [RGB_W-1:0] random_bg();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return RGB_WHITE;
    return $urandom_range(0, (1 << RGB_W) - 1);
  endfunction

  task automatic add_load(input logic [INDEX_W-1:0] idx, input logic [WORD_W-1:0] data);
    pix_req_t req;
    req = scrambled_req();
    req.mode          = MODE_LOAD;
    req.pattern_index = idx;
    req.pattern_word  = data;
    loaded_mem[idx]   = 1'b1;
    pending_words.push_back(req);
    queued_count++;
  endtask

  // a pixel that would read a never-loaded ram word gets that word loaded first
  task automatic add_pixel(input logic [PIX_X_W-1:0] px, input logic [PIX_Y_W-1:0] py,
                           input logic [RGB_W-1:0] bg);
    pix_req_t req;
    int       idx;
    int       col;
    if (cursor_hit_at(px, py, idx, col) && !loaded_mem[idx])
      add_load(idx, $urandom_range(0, (1 << WORD_W) - 1));
    req = scrambled_req();
    req.mode       = MODE_PIXEL;
    req.pixel_x    = px;
    req.pixel_y    = py;
    req.background = bg;
    pending_words.push_back(req);
    queued_count++;
  endtask

  // register write; the copy keeps only the bits each register holds
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_ENABLE:  cursor_cfg.enable      = data[0];
      CFG_POS_X:   cursor_cfg.pos_x       = data[PIX_X_W-1:0];
      CFG_POS_Y:   cursor_cfg.pos_y       = data[PIX_Y_W-1:0];
      CFG_H_OFS:   cursor_cfg.h_offset    = data[OFS_W-1:0];
      CFG_V_OFS:   cursor_cfg.v_offset    = data[OFS_W-1:0];
      CFG_COLOUR0: cursor_cfg.colour_zero = data[RGB_W-1:0];
      CFG_COLOUR1: cursor_cfg.colour_one  = data[RGB_W-1:0];
      default:     ;  // no register there, the block ignores it
    endcase
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] en, x, y, h, v, c0, c1);
    write_reg(CFG_ENABLE, en);
    write_reg(CFG_POS_X, x);
    write_reg(CFG_POS_Y, y);
    write_reg(CFG_H_OFS, h);
    write_reg(CFG_V_OFS, v);
    write_reg(CFG_COLOUR0, c0);
    write_reg(CFG_COLOUR1, c1);
  endtask

  // sender holds off until every queued word is through and answered
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_words.size() != 0 || pix_in.valid || expected_pixels.size() != 0);
    // two-stage pipe, let it settle before touching registers
    repeat (4) @(posedge clk);
  endtask

  // input driver: new words and gaps at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      pix_in.valid <= 1'b0;
      gap_left     <= 0;
    end else if (pix_in.valid && !in_fire) begin
      // word not taken yet, hold it
    end else if (gap_left > 0) begin
      pix_in.valid <= 1'b0;
      gap_left     <= gap_left - 1;
    end else if (pending_words.size() != 0) begin
      cur_req = pending_words.pop_front();
      pix_in.valid         <= 1'b1;
      pix_in.mode          <= cur_req.mode;
      pix_in.pattern_index <= cur_req.pattern_index;
      pix_in.pattern_word  <= cur_req.pattern_word;
      pix_in.pixel_x       <= cur_req.pixel_x;
      pix_in.pixel_y       <= cur_req.pixel_y;
      pix_in.background    <= cur_req.background;
      gap_left             <= idle_len(source_steady);
    end else begin
      pix_in.valid <= 1'b0;
    end
  end

  // output sink: ready drops for random stretches
  always @(negedge clk) begin
    if (rst) begin
      pix_out.ready <= 1'b0;
      stall_left    <= 0;
    end else if (stall_left > 0) begin
      pix_out.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      pix_out.ready <= 1'b1;
      stall_left    <= idle_len(sink_steady);
    end
  end

  // monitor: both handshakes sampled at the rising edge
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      in_fire <= pix_in.valid && pix_in.ready;
      // record the accepted word first in case output follows in the same edge
      if (!rst && pix_in.valid && pix_in.ready) begin
        seen_req.mode          = pix_in.mode;
        seen_req.pattern_index = pix_in.pattern_index;
        seen_req.pattern_word  = pix_in.pattern_word;
        seen_req.pixel_x       = pix_in.pixel_x;
        seen_req.pixel_y       = pix_in.pixel_y;
        seen_req.background    = pix_in.background;
        expected_pixels.push_back(compose_pixel(seen_req));
      end
      if (!rst && pix_out.valid && pix_out.ready) begin
        got_px.pixel = pix_out.pixel_out;
        got_px.hit   = pix_out.cursor_hit;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output word: pixel_out %06h cursor_hit %0b",
                     got_px.pixel, got_px.hit);
        end else begin
          want_px = expected_pixels.pop_front();
          if (got_px.pixel !== want_px.pixel || got_px.hit !== want_px.hit) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected pixel_out %06h cursor_hit %0b, got %06h %0b",
                       want_px.pixel, want_px.hit, got_px.pixel, got_px.hit);
          end
        end
      end
    end
  end

  initial begin
    int pick;
    int phase_end;
    int r;
    rst                  = 1'b1;
    cfg_write            = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    pix_in.valid         = 1'b0;
    pix_in.mode          = MODE_LOAD;
    pix_in.pattern_index = '0;
    pix_in.pattern_word  = '0;
    pix_in.pixel_x       = '0;
    pix_in.pixel_y       = '0;
    pix_in.background    = '0;
    pix_out.ready        = 1'b0;
    cursor_cfg           = '0;
    foreach (pattern_mem[i]) pattern_mem[i] = '0;
    foreach (loaded_mem[i]) loaded_mem[i] = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: cursor at (100, 50), full rows, distinct colours
    apply_setting(1, 100, 50, 0, 0, 24'h123456, 24'hABCDEF);
    // write to the index past the last register must change nothing
    write_reg(CFG_UNUSED, RGB_WHITE);
    add_load(0, 16'hE4E4);                  // codes 0,1,2,3 across the first four columns
    add_load(7, 16'hFFFF);                  // right edge group, all complement
    add_load(496, 16'h0000);                // last drawn row, left group
    add_load(503, 16'hAAAA);                // last drawn row, right group, all transparent
    add_load(STORE_DEPTH - 1, 16'h5555);    // highest ram word, row never drawn here
    add_pixel(100, 50, '0);                 // colour zero
    add_pixel(101, 50, RGB_WHITE);          // colour one
    add_pixel(102, 50, 24'h0F0F0F);         // transparent, still a hit
    add_pixel(103, 50, 24'h00FF00);         // complemented background
    add_pixel(99, 50, 24'h345678);          // left of cursor
    add_pixel(100, 49, 24'h345678);         // above cursor
    add_pixel(163, 50, '0);                 // last column
    add_pixel(164, 50, 24'h777777);         // one past last column
    add_pixel(100, 112, 24'h010203);        // last drawn row
    add_pixel(163, 112, 24'h0A0B0C);        // bottom right corner, transparent
    add_pixel(100, 113, 24'h445566);        // row 63 is never drawn
    add_pixel((1 << PIX_X_W) - 1, (1 << PIX_Y_W) - 1, RGB_WHITE);
    add_pixel(0, 0, '0);
    wait_drained();

    for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
      case (phase)
        // origin at top left, black and white
        1: apply_setting(1, 0, 0, 0, 0, '0, RGB_WHITE);
        // origin at the far corner, only one pixel can land
        2: apply_setting(1, (1 << PIX_X_W) - 1, (1 << PIX_Y_W) - 1, 0, 0, RGB_WHITE, '0);
        // pointer off, pixels pass through
        3: apply_setting(0, $urandom_range(0, RGB_WHITE), $urandom_range(0, RGB_WHITE),
                         $urandom_range(0, 63), $urandom_range(0, 62),
                         $urandom_range(0, RGB_WHITE), $urandom_range(0, RGB_WHITE));
        // largest offsets, nothing drawn
        4: apply_setting(1, $urandom_range(0, 1023), $urandom_range(0, 2047), 255, 255,
                         $urandom_range(0, RGB_WHITE), $urandom_range(0, RGB_WHITE));
        // a single drawn row and a single drawn column
        5: apply_setting(1, $urandom_range(0, 1023), $urandom_range(0, 2047), 63, 62,
                         $urandom_range(0, RGB_WHITE), $urandom_range(0, RGB_WHITE));
        // vertical offset just large enough to hide every row
        6: apply_setting(1, $urandom_range(0, 1023), $urandom_range(0, 2047), 0, 63,
                         $urandom_range(0, RGB_WHITE), $urandom_range(0, RGB_WHITE));
        default: begin
          // junk above the position registers' widths checks the masking too
          r = $urandom_range(0, 3);
          apply_setting(1, $urandom_range(0, RGB_WHITE), $urandom_range(0, RGB_WHITE),
                        (r == 0) ? 0 : $urandom_range(0, 70),
                        (r == 1) ? 0 : $urandom_range(0, 70),
                        $urandom_range(0, RGB_WHITE), $urandom_range(0, RGB_WHITE));
        end
      endcase
      source_steady = ($urandom_range(0, 3) == 0);
      sink_steady   = ($urandom_range(0, 3) == 0);
      phase_end = queued_count + WORDS_PER_PHASE;
      while (queued_count < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 20)
          add_load($urandom_range(0, STORE_DEPTH - 1), $urandom_range(0, (1 << WORD_W) - 1));
        else if (pick < 85)
          // around the pointer, a little past every edge
          add_pixel(cursor_cfg.pos_x + $urandom_range(0, CURSOR_SIZE + 8) - 4,
                    cursor_cfg.pos_y + $urandom_range(0, CURSOR_SIZE + 4) - 4, random_bg());
        else
          add_pixel($urandom_range(0, (1 << PIX_X_W) - 1),
                    $urandom_range(0, (1 << PIX_Y_W) - 1), random_bg());
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
